// ===== design/gpi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the grid patch interpolator.
// No dependencies; every other design file refers to this package.
package gpi_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int FIELD_W         = 32;
    localparam int CFG_IDX_W       = 3;

    // Horner intermediates live in +-2^61, which needs 63 signed bits.
    localparam int ACC_W   = 63;
    localparam int WIDE_W  = ACC_W + 4;
    // Split point of the upper multiplier operand into two narrow products.
    localparam int SPLIT_K = 28;

    localparam logic signed [ACC_W-1:0] LIM = 63'sh2000_0000_0000_0000;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_QUERY     = 1'b1;
    localparam logic MODE_BICUBIC = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_X_MIN = 3'd1,
        REG_X_MAX = 3'd2,
        REG_Y_MIN = 3'd3,
        REG_Y_MAX = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_WIDTH = 2'd1,
        ST_SAT        = 2'd2
    } status_t;

    // Coefficients of one Horner chain: y = addend + g(t*(a + t*(b + t*c)))
    typedef struct packed {
        logic signed [ACC_W-1:0] c;
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] addend;
        logic                    halve;
    } gpi_coef_t;

    // Cubic mode gives Catmull-Rom terms; linear mode maps v1 + (v2 - v1) * t
    // onto the same chain with c and b held at zero.
    function automatic gpi_coef_t make_coef(input logic signed [ACC_W-1:0] v0,
                                            input logic signed [ACC_W-1:0] v1,
                                            input logic signed [ACC_W-1:0] v2,
                                            input logic signed [ACC_W-1:0] v3,
                                            input logic cubic,
                                            input logic lane_on);
        gpi_coef_t r;
        r = '0;
        if (cubic) begin
            r.c      = 3 * (v1 - v2) + v3 - v0;
            r.b      = (v0 <<< 1) - 5 * v1 + (v2 <<< 2) - v3;
            r.a      = v2 - v0;
            r.addend = v1;
            r.halve  = 1'b1;
        end
        else if (lane_on) begin
            r.a      = v2 - v1;
            r.addend = v1;
        end
        return r;
    endfunction

    // Clamp to +-2^61 and flag the clamp.
    function automatic logic signed [ACC_W-1:0] clamp_lim(input logic signed [WIDE_W-1:0] v,
                                                          output logic hit);
        logic signed [WIDE_W-1:0] lim_w;
        lim_w = WIDE_W'(LIM);
        hit = (v > lim_w) || (v < -lim_w);
        if (v > lim_w) begin
            return LIM;
        end
        else if (v < -lim_w) begin
            return -LIM;
        end
        return $signed(v[ACC_W-1:0]);
    endfunction

endpackage

// ===== design/gpi_in_if.sv =====
`timescale 1ns / 1ps
// Input item channel: load or query items with valid/ready.
// Depends on gpi_pkg for field widths.
interface gpi_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [1:0]                          sample_row;
    logic [1:0]                          sample_col;
    logic signed [gpi_pkg::FIELD_W-1:0]  sample_height;
    logic signed [gpi_pkg::FIELD_W-1:0]  point_x;
    logic signed [gpi_pkg::FIELD_W-1:0]  point_y;

    modport source (output valid, operation, sample_row, sample_col, sample_height,
                    point_x, point_y, input ready);
    modport sink (input valid, operation, sample_row, sample_col, sample_height,
                  point_x, point_y, output ready);
endinterface

// ===== design/gpi_out_if.sv =====
`timescale 1ns / 1ps
// Result item channel with valid/ready.
// Depends on gpi_pkg for field widths.
interface gpi_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [gpi_pkg::FIELD_W-1:0]  interp_value;
    logic [1:0]                          status;

    modport source (output valid, interp_value, status, input ready);
    modport sink (input valid, interp_value, status, output ready);
endinterface

// ===== design/gpi_cfg_if.sv =====
`timescale 1ns / 1ps
// Register write channel: index and data with valid/ready.
// Depends on gpi_pkg for widths.
interface gpi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gpi_pkg::CFG_IDX_W-1:0]     index;
    logic [gpi_pkg::FIELD_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/grid_patch_interpolator.sv =====
`timescale 1ns / 1ps
// Top level of the grid patch interpolator: patch store, normalizers, row and
// column passes. Depends on gpi_pkg, the channel interfaces, gpi_div, gpi_cubic.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------------
//  query    | in  | valid/ready  | operation, sample_row/col/height, point_x/y
//  result   | out | valid/ready  | interp_value, status
//  cfg      | in  | valid/ready  | index, data (ready always high)
//
// One item enters per cycle while the pipeline is not stalled. A query goes
// through the normalizer, which retires one quotient bit per stage, then
// two 12-stage Horner passes with a row saturation and a coefficient stage
// between. Loads take effect at once and give no result. The whole pipeline
// stalls together while the output register holds a result that is not
// taken; nothing is dropped or repeated.
// Reset clears the patch to zero and loads the register defaults.
module grid_patch_interpolator #(
    parameter int VALUE_WIDTH = gpi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = gpi_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gpi_in_if.sink      query,
    gpi_out_if.source   result,
    gpi_cfg_if.sink     cfg
);
    localparam int ACC_W   = gpi_pkg::ACC_W;
    localparam int FIELD_W = gpi_pkg::FIELD_W;
    localparam int T_W     = FRAC_BITS + 4;
    // gpi_div stages: difference, magnitude, T_W + 1 bit stages, saturation
    localparam int L_DIV   = T_W + 4;
    localparam int PASS    = 12;
    localparam int TY_DL   = PASS + 2;
    localparam int NSTG    = L_DIV + 2 * PASS + 4;

    localparam logic signed [ACC_W-1:0] VMAX =
        ACC_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;

    function automatic logic signed [ACC_W-1:0] sat_vw(input logic signed [ACC_W-1:0] v,
                                                       output logic hit);
        hit = (v > VMAX) || (v < VMIN);
        if (v > VMAX)
        begin
            return VMAX;
        end
        else if (v < VMIN)
        begin
            return VMIN;
        end
        return v;
    endfunction

    // ---------------- configuration registers ----------------
    logic                      mode_reg;
    logic signed [FIELD_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;

    assign cfg.ready = 1'b1;

    // ---------------- flow control ----------------
    // Advance everything unless the output register holds an untaken result.
    logic vq_reg [NSTG];
    logic en;
    logic in_fire;
    assign en          = !vq_reg[NSTG-1] || result.ready;
    assign query.ready = en;
    assign in_fire     = query.valid && en;

    // ---------------- patch store ----------------
    logic signed [VALUE_WIDTH-1:0] patch_reg [16];
    logic signed [ACC_W-1:0]       load_val;
    logic                          load_hit;
    always_comb
    begin
        load_val = sat_vw(ACC_W'(query.sample_height), load_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= gpi_pkg::MODE_BICUBIC;
            x_min_reg <= '0;
            x_max_reg <= FIELD_W'(65536);
            y_min_reg <= '0;
            y_max_reg <= FIELD_W'(65536);
            for (int i = 0; i < 16; i++)
            begin
                patch_reg[i] <= '0;
            end
            for (int i = 0; i < NSTG; i++)
            begin
                vq_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (gpi_pkg::cfg_reg_t'(cfg.index))
                    gpi_pkg::REG_MODE:  mode_reg  <= cfg.data[0];
                    gpi_pkg::REG_X_MIN: x_min_reg <= $signed(cfg.data);
                    gpi_pkg::REG_X_MAX: x_max_reg <= $signed(cfg.data);
                    gpi_pkg::REG_Y_MIN: y_min_reg <= $signed(cfg.data);
                    gpi_pkg::REG_Y_MAX: y_max_reg <= $signed(cfg.data);
                    default: ;
                endcase
            end
            // Store a sample the moment its item is accepted.
            if (in_fire && query.operation == gpi_pkg::OP_LOAD)
            begin
                patch_reg[{query.sample_row, query.sample_col}] <= load_val[VALUE_WIDTH-1:0];
            end
            if (en)
            begin
                vq_reg[0] <= in_fire && query.operation == gpi_pkg::OP_QUERY;
                for (int i = 1; i < NSTG; i++)
                begin
                    vq_reg[i] <= vq_reg[i-1];
                end
            end
        end
    end

    // ---------------- accept stage and patch snapshot ----------------
    // Snapshot the patch with the query so later loads cannot reach it.
    logic signed [FIELD_W-1:0]     px_reg, py_reg;
    logic signed [VALUE_WIDTH-1:0] h_dl [L_DIV][16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= query.point_x;
            py_reg  <= query.point_y;
            h_dl[0] <= patch_reg;
            for (int i = 1; i < L_DIV; i++)
            begin
                h_dl[i] <= h_dl[i-1];
            end
        end
    end

    // ---------------- normalizers ----------------
    logic signed [T_W-1:0] tx, ty;
    logic                  tx_sat, ty_sat;

    gpi_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .en(en), .p(px_reg), .lo(x_min_reg), .hi(x_max_reg),
        .t(tx), .sat(tx_sat)
    );

    gpi_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .en(en), .p(py_reg), .lo(y_min_reg), .hi(y_max_reg),
        .t(ty), .sat(ty_sat)
    );

    // ---------------- row pass along x ----------------
    // Coefficients land in step with the normalized t.
    gpi_pkg::gpi_coef_t xcoef_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                xcoef_reg[r] <= gpi_pkg::make_coef(ACC_W'(h_dl[L_DIV-1][r*4]),
                                                   ACC_W'(h_dl[L_DIV-1][r*4+1]),
                                                   ACC_W'(h_dl[L_DIV-1][r*4+2]),
                                                   ACC_W'(h_dl[L_DIV-1][r*4+3]),
                                                   mode_reg, (r == 1) || (r == 2));
            end
        end
    end

    logic signed [T_W-1:0]   ty_dl [TY_DL];
    logic                    tsat;
    logic signed [ACC_W-1:0] row_y [4];
    logic                    row_s [4];

    assign tsat = tx_sat | ty_sat;

    // Hold ty until the column coefficients are ready.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ty_dl[0] <= ty;
            for (int i = 1; i < TY_DL; i++)
            begin
                ty_dl[i] <= ty_dl[i-1];
            end
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        gpi_cubic #(.FRAC_BITS(FRAC_BITS)) u_row (
            .clk(clk), .en(en), .coef(xcoef_reg[r]), .t(tx),
            .sat_in((r == 0) ? tsat : 1'b0), .y(row_y[r]), .sat_out(row_s[r])
        );
    end

    // ---------------- row saturation and column coefficients ----------------
    logic signed [ACC_W-1:0] row_reg [4];
    logic                    row_sat_reg;
    logic signed [ACC_W-1:0] row_next [4];
    logic                    row_hit [4];
    logic                    row_sat_next;

    always_comb
    begin
        row_sat_next = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            row_next[r]  = sat_vw(row_y[r], row_hit[r]);
            row_sat_next = row_sat_next | row_hit[r] | row_s[r];
        end
    end

    gpi_pkg::gpi_coef_t ycoef_reg;
    logic               ysat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg     <= row_next;
            row_sat_reg <= row_sat_next;
            ycoef_reg   <= gpi_pkg::make_coef(row_reg[0], row_reg[1], row_reg[2], row_reg[3],
                                              mode_reg, 1'b1);
            ysat_reg    <= row_sat_reg;
        end
    end

    // ---------------- column pass along y ----------------
    logic signed [ACC_W-1:0] col_y;
    logic                    col_s;

    gpi_cubic #(.FRAC_BITS(FRAC_BITS)) u_col (
        .clk(clk), .en(en), .coef(ycoef_reg), .t(ty_dl[TY_DL-1]),
        .sat_in(ysat_reg), .y(col_y), .sat_out(col_s)
    );

    // ---------------- output register ----------------
    logic signed [ACC_W-1:0]   res_val;
    logic                      res_hit;
    logic                      zero_width;
    logic signed [FIELD_W-1:0] value_reg;
    logic [1:0]                status_reg;

    always_comb
    begin
        res_val    = sat_vw(col_y, res_hit);
        zero_width = (x_max_reg == x_min_reg) || (y_max_reg == y_min_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_width)
            begin
                value_reg  <= '0;
                status_reg <= gpi_pkg::ST_ZERO_WIDTH;
            end
            else
            begin
                value_reg  <= res_val[FIELD_W-1:0];
                status_reg <= (col_s || res_hit) ? gpi_pkg::ST_SAT : gpi_pkg::ST_OK;
            end
        end
    end

    assign result.valid        = vq_reg[NSTG-1];
    assign result.interp_value = value_reg;
    assign result.status       = status_reg;
endmodule

// ===== design/gpi_div.sv =====
`timescale 1ns / 1ps
// Pipelined normalizer t = ((p - lo) << FRAC_BITS) / (hi - lo), one quotient
// bit per stage, saturated to signed Q4.FRAC_BITS. Depends on gpi_pkg.
module gpi_div #(
    parameter int FRAC_BITS = gpi_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [gpi_pkg::FIELD_W-1:0] p,
    input  logic signed [gpi_pkg::FIELD_W-1:0] lo,
    input  logic signed [gpi_pkg::FIELD_W-1:0] hi,
    output logic signed [FRAC_BITS+3:0]        t,
    output logic                               sat
);
    localparam int QB     = FRAC_BITS + 4;
    localparam int DIFF_W = gpi_pkg::FIELD_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_BITS;
    localparam int CW     = DIFF_W + QB + 1;
    localparam logic [QB-1:0] HALF = {1'b1, {(QB-1){1'b0}}};
    localparam logic [QB-1:0] TMAX = {1'b0, {(QB-1){1'b1}}};

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] den_reg;

    logic [NUM_W-1:0]  r_st   [QB+2];
    logic [DIFF_W-1:0] d_st   [QB+2];
    logic [QB:0]       q_st   [QB+2];
    logic              neg_st [QB+2];

    logic signed [QB-1:0] t_reg;
    logic                 sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg  <= DIFF_W'(p) - DIFF_W'(lo);
            den_reg   <= DIFF_W'(hi) - DIFF_W'(lo);
            r_st[0]   <= {(diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg)),
                          {FRAC_BITS{1'b0}}};
            d_st[0]   <= den_reg[DIFF_W-1] ? DIFF_W'(-den_reg) : DIFF_W'(den_reg);
            q_st[0]   <= '0;
            neg_st[0] <= diff_reg[DIFF_W-1] ^ den_reg[DIFF_W-1];
        end
    end

    // Stage j tests the quotient bit of weight 2^(QB-j); the top bit is overflow.
    for (genvar j = 0; j <= QB; j++)
    begin : g_step
        localparam int SH = QB - j;
        logic [CW-1:0] rr;
        logic [CW-1:0] dsh;
        assign rr  = CW'(r_st[j]);
        assign dsh = CW'(d_st[j]) << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_st[j+1]   <= d_st[j];
                neg_st[j+1] <= neg_st[j];
                if (rr >= dsh)
                begin
                    r_st[j+1]     <= NUM_W'(rr - dsh);
                    q_st[j+1]     <= q_st[j] | ((QB+1)'(1) << SH);
                end
                else
                begin
                    r_st[j+1] <= r_st[j];
                    q_st[j+1] <= q_st[j];
                end
            end
        end
    end

    logic [QB-1:0] mag;
    logic          ovf;
    logic          neg;
    logic          over;
    assign mag  = q_st[QB+1][QB-1:0];
    assign ovf  = q_st[QB+1][QB];
    assign neg  = neg_st[QB+1];
    assign over = ovf || (neg ? (mag > HALF) : mag[QB-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= over;
            if (over)
            begin
                t_reg <= $signed(neg ? HALF : TMAX);
            end
            else
            begin
                t_reg <= $signed(neg ? (~mag + QB'(1)) : mag);
            end
        end
    end

    assign t   = t_reg;
    assign sat = sat_reg;
endmodule

// ===== design/gpi_mac.sv =====
`timescale 1ns / 1ps
// Four-stage multiply-shift-add: y = clamp(g(floor(x*t / 2^FRAC_BITS)) + add),
// g optionally a floor halving. Depends on gpi_pkg.
module gpi_mac #(
    parameter int FRAC_BITS = gpi_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [gpi_pkg::ACC_W-1:0]   x,
    input  logic signed [gpi_pkg::ACC_W-1:0]   add,
    input  logic                               halve,
    input  logic signed [FRAC_BITS+3:0]        t,
    input  logic                               sat_in,
    output logic signed [gpi_pkg::ACC_W-1:0]   y,
    output logic                               sat_out
);
    localparam int ACC_W  = gpi_pkg::ACC_W;
    localparam int WIDE_W = gpi_pkg::WIDE_W;
    localparam int K      = gpi_pkg::SPLIT_K;
    localparam int T_W    = FRAC_BITS + 4;
    localparam int HI_W   = ACC_W - FRAC_BITS;
    localparam int HH_W   = HI_W - K;

    logic signed [HI_W-1:0]           hi;
    logic signed [HH_W-1:0]           hh;
    logic [K-1:0]                     hl;
    logic [FRAC_BITS-1:0]             lo;
    logic signed [HH_W+T_W-1:0]       m_hh;
    logic signed [K+T_W:0]            m_hl;
    logic signed [FRAC_BITS+T_W:0]    m_lo;

    assign hi   = x[ACC_W-1:FRAC_BITS];
    assign hh   = hi[HI_W-1:K];
    assign hl   = hi[K-1:0];
    assign lo   = x[FRAC_BITS-1:0];
    assign m_hh = hh * t;
    assign m_hl = $signed({1'b0, hl}) * t;
    assign m_lo = $signed({1'b0, lo}) * t;

    logic signed [HH_W+T_W-1:0] hh1_reg;
    logic signed [K+T_W:0]      hl1_reg;
    logic signed [T_W:0]        part1_reg;
    logic signed [ACC_W-1:0]    add1_reg;
    logic                       halve1_reg;
    logic                       sat1_reg;

    logic signed [WIDE_W-1:0]   prod2_reg;
    logic signed [T_W:0]        part2_reg;
    logic signed [ACC_W-1:0]    add2_reg;
    logic                       halve2_reg;
    logic                       sat2_reg;

    logic signed [ACC_W-1:0]    ms3_reg;
    logic signed [ACC_W-1:0]    add3_reg;
    logic                       halve3_reg;
    logic                       sat3_reg;

    logic signed [ACC_W-1:0]    y_reg;
    logic                       sat4_reg;

    // Stage 3: an oversized upper product saturates outright.
    logic                       ovf3;
    logic                       hit3;
    logic signed [ACC_W-1:0]    ms3_next;
    always_comb
    begin
        ovf3 = (prod2_reg > WIDE_W'(gpi_pkg::LIM)) || (prod2_reg < -WIDE_W'(gpi_pkg::LIM));
        ms3_next = gpi_pkg::clamp_lim(prod2_reg + WIDE_W'(part2_reg), hit3);
        if (ovf3)
        begin
            ms3_next = (prod2_reg < 0) ? -gpi_pkg::LIM : gpi_pkg::LIM;
            hit3     = 1'b1;
        end
    end

    logic signed [ACC_W-1:0]    g4;
    logic                       hit4;
    logic signed [ACC_W-1:0]    y_next;
    always_comb
    begin
        g4     = halve3_reg ? (ms3_reg >>> 1) : ms3_reg;
        y_next = gpi_pkg::clamp_lim(WIDE_W'(g4) + WIDE_W'(add3_reg), hit4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh1_reg    <= m_hh;
            hl1_reg    <= m_hl;
            part1_reg  <= m_lo[FRAC_BITS+T_W:FRAC_BITS];
            add1_reg   <= add;
            halve1_reg <= halve;
            sat1_reg   <= sat_in;

            prod2_reg  <= (WIDE_W'(hh1_reg) <<< K) + WIDE_W'(hl1_reg);
            part2_reg  <= part1_reg;
            add2_reg   <= add1_reg;
            halve2_reg <= halve1_reg;
            sat2_reg   <= sat1_reg;

            ms3_reg    <= ms3_next;
            add3_reg   <= add2_reg;
            halve3_reg <= halve2_reg;
            sat3_reg   <= sat2_reg | hit3;

            y_reg      <= y_next;
            sat4_reg   <= sat3_reg | hit4;
        end
    end

    assign y       = y_reg;
    assign sat_out = sat4_reg;
endmodule

// ===== design/gpi_cubic.sv =====
`timescale 1ns / 1ps
// Horner evaluation of one cubic or linear segment over three chained MACs,
// twelve stages deep. Depends on gpi_pkg and gpi_mac.
module gpi_cubic #(
    parameter int FRAC_BITS = gpi_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  gpi_pkg::gpi_coef_t                 coef,
    input  logic signed [FRAC_BITS+3:0]        t,
    input  logic                               sat_in,
    output logic signed [gpi_pkg::ACC_W-1:0]   y,
    output logic                               sat_out
);
    localparam int ACC_W = gpi_pkg::ACC_W;
    localparam int LAT   = 4;

    logic signed [FRAC_BITS+3:0] t_dl  [2*LAT];
    logic signed [ACC_W-1:0]     a_dl  [LAT];
    logic signed [ACC_W-1:0]     v_dl  [2*LAT];
    logic                        h_dl  [2*LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_dl[0] <= t;
            a_dl[0] <= coef.a;
            v_dl[0] <= coef.addend;
            h_dl[0] <= coef.halve;
            for (int i = 1; i < 2*LAT; i++)
            begin
                t_dl[i] <= t_dl[i-1];
                v_dl[i] <= v_dl[i-1];
                h_dl[i] <= h_dl[i-1];
            end
            for (int i = 1; i < LAT; i++)
            begin
                a_dl[i] <= a_dl[i-1];
            end
        end
    end

    logic signed [ACC_W-1:0] y1, y2;
    logic                    s1, s2;

    gpi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_c (
        .clk(clk), .en(en), .x(coef.c), .add(coef.b), .halve(1'b0), .t(t),
        .sat_in(sat_in), .y(y1), .sat_out(s1)
    );

    gpi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_b (
        .clk(clk), .en(en), .x(y1), .add(a_dl[LAT-1]), .halve(1'b0), .t(t_dl[LAT-1]),
        .sat_in(s1), .y(y2), .sat_out(s2)
    );

    gpi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_a (
        .clk(clk), .en(en), .x(y2), .add(v_dl[2*LAT-1]), .halve(h_dl[2*LAT-1]),
        .t(t_dl[2*LAT-1]), .sat_in(s2), .y(y), .sat_out(sat_out)
    );
endmodule
